>>> rtl/core/rrqs_pkg.sv
package rrqs_pkg;

  localparam int NUM_TASKS = 16;
  localparam int TASK_W    = $clog2(NUM_TASKS);
  localparam int COUNT_W   = TASK_W + 1;
  localparam int QUANTUM_W = 8;
  localparam int QLEFT_W   = QUANTUM_W + 1;

  localparam logic [QUANTUM_W-1:0] QUANTUM_AT_RESET = QUANTUM_W'(5);
  localparam logic [QLEFT_W-1:0]   QLEFT_MIN        = {1'b1, {(QLEFT_W-1){1'b0}}};

  // task states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_PARKED  = 2'd3;

  // event codes
  localparam logic [1:0] FN_TICK  = 2'd0;
  localparam logic [1:0] FN_READY = 2'd1;
  localparam logic [1:0] FN_BLOCK = 2'd2;
  localparam logic [1:0] FN_SETQ  = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic [3:0]           task_id;
    logic [QUANTUM_W-1:0] quantum_value;
  } rrqs_in_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       idle_running;
    logic       switched;
    logic       status;
  } rrqs_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic pop_pending;
  } dp_status_t;

endpackage

>>> rtl/core/rrqs_ram.sv
module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/rrqs_ctrl.sv
module rrqs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rrqs_pkg::dp_status_t dp_status,
  output rrqs_pkg::dp_cmd_t   dp_cmd,
  output logic                busy,
  output logic                done
);
  import rrqs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = dp_status.pop_pending ? S_POP : S_DONE;
      end
      S_POP: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign dp_cmd.load   = start && (state == S_IDLE);
  assign dp_cmd.exec   = (state == S_EXEC);
  assign dp_cmd.finish = (state == S_POP);

endmodule

>>> rtl/core/rrqs_dp.sv
module rrqs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rrqs_pkg::dp_cmd_t                   dp_cmd,
  output rrqs_pkg::dp_status_t                dp_status,
  input  rrqs_pkg::rrqs_in_t                  cmd,
  output rrqs_pkg::rrqs_out_t                 result,
  input  logic                                cfg_we,
  input  logic [rrqs_pkg::QUANTUM_W-1:0]      cfg_data
);
  import rrqs_pkg::*;

  rrqs_in_t             op;
  logic [TASK_W-1:0]    before_task;
  logic                 before_idle;
  logic                 status_r;
  logic [QUANTUM_W-1:0] default_q;
  logic [1:0]           task_state [NUM_TASKS];
  logic [QUANTUM_W-1:0] task_quantum [NUM_TASKS];
  logic [QLEFT_W-1:0]   quantum_left;
  logic [TASK_W-1:0]    current_task;
  logic                 idle_flag;
  logic [TASK_W-1:0]    head;
  logic [TASK_W-1:0]    tail;
  logic [COUNT_W-1:0]   count;

  logic [TASK_W-1:0]    op_id;
  logic                 id_ok;
  logic [1:0]           st_id;
  logic [QLEFT_W-1:0]   ql_dec;
  logic                 ql_low;
  logic                 push_en;
  logic [TASK_W-1:0]    push_id;
  logic                 push_ok;
  logic                 pop_en;
  logic                 st_we;
  logic [TASK_W-1:0]    st_waddr;
  logic [1:0]           st_wdata;
  logic                 q_we;
  logic [QUANTUM_W-1:0] q_wdata;
  logic                 ql_we;
  logic                 idle_set;
  logic                 status_n;
  logic [TASK_W-1:0]    fifo_rdata;

  assign op_id  = TASK_W'(op.task_id);
  assign id_ok  = ({1'b0, op.task_id} < 5'(NUM_TASKS));
  assign st_id  = task_state[op_id];
  assign ql_dec = (quantum_left != QLEFT_MIN) ? quantum_left - 1'b1 : quantum_left;
  assign ql_low = ql_dec[QLEFT_W-1] || (ql_dec == '0);

  always_comb begin
    push_en  = 1'b0;
    push_id  = current_task;
    pop_en   = 1'b0;
    st_we    = 1'b0;
    st_waddr = current_task;
    st_wdata = ST_QUEUED;
    q_we     = 1'b0;
    q_wdata  = op.quantum_value;
    ql_we    = 1'b0;
    idle_set = 1'b0;
    status_n = 1'b0;
    if (dp_cmd.exec) begin
      unique case (op.func)
        FN_TICK: begin
          ql_we = 1'b1;
          if (ql_low && (count != '0)) begin
            // preempt: requeue the running task, then take the head
            if (!idle_flag) begin
              st_we    = 1'b1;
              st_wdata = ST_QUEUED;
              push_en  = 1'b1;
            end
            pop_en = 1'b1;
          end
        end
        FN_READY: begin
          if (!id_ok) begin
            status_n = 1'b1;
          end else if ((st_id == ST_FREE) || (st_id == ST_PARKED)) begin
            if (st_id == ST_FREE) begin
              q_we    = 1'b1;
              q_wdata = default_q;
            end
            st_we    = 1'b1;
            st_waddr = op_id;
            st_wdata = ST_QUEUED;
            push_en  = 1'b1;
            push_id  = op_id;
          end else begin
            status_n = 1'b1;
          end
        end
        FN_BLOCK: begin
          if (idle_flag) begin
            status_n = 1'b1;
          end else begin
            st_we    = 1'b1;
            st_wdata = ST_PARKED;
            if (count != '0) begin
              pop_en = 1'b1;
            end else begin
              idle_set = 1'b1;
            end
          end
        end
        FN_SETQ: begin
          if (id_ok) begin
            q_we = 1'b1;
          end else begin
            status_n = 1'b1;
          end
        end
      endcase
    end else if (dp_cmd.finish) begin
      st_we    = 1'b1;
      st_waddr = fifo_rdata;
      st_wdata = ST_RUNNING;
    end
  end

  assign push_ok = push_en && (count != COUNT_W'(NUM_TASKS));
  assign dp_status.pop_pending = pop_en;

  rrqs_ram #(
    .WIDTH (TASK_W),
    .DEPTH (NUM_TASKS)
  ) u_fifo (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail),
    .wdata (push_id),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op          <= cmd;
      before_task <= current_task;
      before_idle <= idle_flag;
    end
    if (dp_cmd.exec) begin
      status_r <= status_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_q    <= QUANTUM_AT_RESET;
      quantum_left <= '0;
      current_task <= '0;
      idle_flag    <= 1'b1;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_state[i]   <= ST_FREE;
        task_quantum[i] <= QUANTUM_AT_RESET;
      end
    end else begin
      if (cfg_we) begin
        default_q <= cfg_data;
      end
      if (st_we) begin
        task_state[st_waddr] <= st_wdata;
      end
      if (q_we) begin
        task_quantum[op_id] <= q_wdata;
      end
      if (ql_we) begin
        quantum_left <= ql_dec;
      end
      if (idle_set) begin
        idle_flag <= 1'b1;
      end
      if (push_ok) begin
        tail <= (tail == TASK_W'(NUM_TASKS - 1)) ? '0 : tail + 1'b1;
      end
      if (pop_en) begin
        head <= (head == TASK_W'(NUM_TASKS - 1)) ? '0 : head + 1'b1;
      end
      count <= count + COUNT_W'(push_ok) - COUNT_W'(pop_en);
      if (dp_cmd.finish) begin
        quantum_left <= {1'b0, task_quantum[fifo_rdata]};
        current_task <= fifo_rdata;
        idle_flag    <= 1'b0;
      end
    end
  end

  assign result.running_task = idle_flag ? '0 : 4'(current_task);
  assign result.idle_running = idle_flag;
  assign result.switched     = (idle_flag != before_idle) ||
                               (!idle_flag && (current_task != before_task)) ||
                               ((op.func == FN_BLOCK) && !status_r);
  assign result.status       = status_r;

endmodule

>>> rtl/core/round_robin_quantum_scheduler.sv
// Round-robin task scheduler with a per-task quantum.
// Command channel: present an event word on cmd and raise start; the word is
// taken at the clock edge where start is high and busy is low. busy stays high
// until the result has been shown, so events are handled one at a time.
// Result channel: done is high for exactly one cycle and result carries the
// word for that event in that cycle only. The receiver cannot hold it off;
// it must take the word when done is high.
// Sequence: after acceptance the event passes the execute state and then the
// done state, with a pop state between them when the event dispatches a task
// from the ready queue (the queue sits in a RAM with registered read). A new
// event can be accepted in the cycle after done.
// Configuration: cfg_data writes the default quantum when cfg_valid is high;
// cfg_ready is always high. Write only while busy is low.
// Reset (rst, synchronous): all tasks free with quantum 5, queue empty,
// idle task running, default quantum 5. The queue RAM is not cleared; only
// entries that have been pushed are ever read.
module round_robin_quantum_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rrqs_pkg::rrqs_in_t              cmd,
  output logic                            done,
  output rrqs_pkg::rrqs_out_t             result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrqs_pkg::QUANTUM_W-1:0]  cfg_data
);
  import rrqs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // config register is always writable
  assign cfg_ready = 1'b1;

  // sequence each event: latch, execute, optional pop, present
  rrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy),
    .done      (done)
  );

  // task tables, ready queue and quantum counter
  rrqs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .cmd       (cmd),
    .result    (result),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data)
  );

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  a_done_release : assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result word");

  a_done_in_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> busy && $past(busy))
    else $error("result word without an event in flight");
`endif

endmodule

>>> tb/sv/round_robin_quantum_scheduler_tb.sv
module round_robin_quantum_scheduler_tb;
  import rrqs_pkg::*;

  // Stimulus plan row: one event word, plus an optional typed expectation
  typedef struct {
    rrqs_in_t  word;
    bit        typed;
    rrqs_out_t want;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  rrqs_in_t             cmd;
  logic                 done;
  rrqs_out_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [QUANTUM_W-1:0] cfg_data;

  round_robin_quantum_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Scheduler mirror: task table, ready queue, quantum counter, running task
  logic [1:0]           task_st [NUM_TASKS];
  logic [QUANTUM_W-1:0] task_qt [NUM_TASKS];
  logic [TASK_W-1:0]    ready_ids [$];
  logic signed [QLEFT_W-1:0] ticks_left;
  logic [TASK_W-1:0]    cur_task;
  bit                   idle_on;
  logic [QUANTUM_W-1:0] dflt_quantum;

  rrqs_out_t  pending_words [$];
  plan_row_t  plan [$];
  rrqs_out_t  due;
  bit         failed;
  bit         gaps_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("round_robin_quantum_scheduler_tb failed");
    $finish;
  end

  function automatic void clear_schedule();
    for (int i = 0; i < NUM_TASKS; i++) begin
      task_st[i] = ST_FREE;
      task_qt[i] = QUANTUM_AT_RESET;
    end
    ready_ids.delete();
    ticks_left   = '0;
    cur_task     = '0;
    idle_on      = 1'b1;
    dflt_quantum = QUANTUM_AT_RESET;
  endfunction

  // Pop the queue head into the running slot, or fall back to idle
  function automatic void run_next();
    logic [TASK_W-1:0] id;
    if (ready_ids.size() != 0) begin
      id         = ready_ids.pop_front();
      ticks_left = $signed({1'b0, task_qt[id]});
      task_st[id] = ST_RUNNING;
      cur_task   = id;
      idle_on    = 1'b0;
    end else begin
      idle_on = 1'b1;
    end
  endfunction

  // Advance the mirror by one event and return the word the block should show.
  // Task ids are 4 bits wide and NUM_TASKS is 16, so every id is in range.
  function automatic rrqs_out_t schedule_event(rrqs_in_t w);
    rrqs_out_t         r;
    logic [TASK_W-1:0] was_task;
    bit                was_idle;
    bit                ignored;
    was_task = cur_task;
    was_idle = idle_on;
    ignored  = 1'b0;
    case (w.func)
      FN_TICK: begin
        // saturate at the most negative count
        if (ticks_left != $signed(QLEFT_MIN)) ticks_left = ticks_left - 9'sd1;
        if (ticks_left <= 0 && ready_ids.size() != 0) begin
          if (!idle_on) begin
            task_st[cur_task] = ST_QUEUED;
            ready_ids.push_back(cur_task);
          end
          run_next();
        end
      end
      FN_READY: begin
        if (task_st[w.task_id] == ST_FREE || task_st[w.task_id] == ST_PARKED) begin
          if (task_st[w.task_id] == ST_FREE) task_qt[w.task_id] = dflt_quantum;
          task_st[w.task_id] = ST_QUEUED;
          ready_ids.push_back(w.task_id);
        end else begin
          ignored = 1'b1;
        end
      end
      FN_BLOCK: begin
        if (idle_on) begin
          ignored = 1'b1;
        end else begin
          task_st[cur_task] = ST_PARKED;
          run_next();
        end
      end
      default: task_qt[w.task_id] = w.quantum_value;
    endcase
    r.running_task = idle_on ? '0 : cur_task;
    r.idle_running = idle_on;
    r.switched     = (idle_on != was_idle) || (!idle_on && cur_task != was_task) ||
                     (w.func == FN_BLOCK && !ignored);
    r.status       = ignored;
    return r;
  endfunction

  // Favour small quanta so that preemption happens often; keep the extremes
  function automatic logic [QUANTUM_W-1:0] pick_quantum();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return QUANTUM_W'($urandom_range(0, 255));
      default: return QUANTUM_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Random event, steered by the mirror: make-ready mostly hits a task that
  // can actually be queued, so the queue fills and rotates
  function automatic rrqs_in_t random_word();
    rrqs_in_t          w;
    logic [TASK_W-1:0] wakeable [$];
    int                pick;
    w.task_id       = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    w.quantum_value = pick_quantum();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.func = FN_TICK;
    end else if (pick < 70) begin
      w.func = FN_READY;
      for (int i = 0; i < NUM_TASKS; i++)
        if (task_st[i] == ST_FREE || task_st[i] == ST_PARKED) wakeable.push_back(TASK_W'(i));
      if (wakeable.size() != 0 && $urandom_range(0, 4) != 0)
        w.task_id = wakeable[$urandom_range(0, wakeable.size() - 1)];
    end else if (pick < 85) begin
      w.func = FN_BLOCK;
    end else begin
      w.func = FN_SETQ;
    end
    return w;
  endfunction

  function automatic void add_row(logic [1:0] f, logic [3:0] id, logic [7:0] qv, bit typed,
                                  logic [3:0] rt, logic ir, logic sw, logic st);
    plan_row_t row;
    row.word = '{func: f, task_id: id, quantum_value: qv};
    row.typed = typed;
    row.want  = '{running_task: rt, idle_running: ir, switched: sw, status: st};
    plan.push_back(row);
  endfunction

  // Present one word and hold start until the block takes it; called just
  // after a falling edge and returns just after a falling edge once it is taken
  task automatic send_word(rrqs_in_t w, bit typed, rrqs_out_t want);
    rrqs_out_t predicted;
    start <= 1'b1;
    cmd   <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = schedule_event(w);
    pending_words.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  // Drop start and wait until every word owed has come back
  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_default(logic [QUANTUM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    dflt_quantum = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, bit allow_gaps);
    for (int i = 0; i < n; i++) begin
      // switch idling on and off in stretches
      if (i % 50 == 0) gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
      maybe_pause();
      send_word(random_word(), 1'b0, '0);
    end
  endtask

  // Block every task until idle runs, then tick long enough to drive the
  // quantum counter into saturation; a task made ready must still be picked up
  task automatic starve_then_wake();
    rrqs_in_t w;
    w = '{func: FN_BLOCK, task_id: '0, quantum_value: '0};
    while (!idle_on) send_word(w, 1'b0, '0);
    w.func = FN_TICK;
    repeat (520) send_word(w, 1'b0, '0);
    w = '{func: FN_READY, task_id: TASK_W'($urandom_range(0, NUM_TASKS - 1)),
          quantum_value: '0};
    send_word(w, 1'b0, '0);
    w.func = FN_TICK;
    send_word(w, 1'b0, '0);
  endtask

  // Compare each shown word with the oldest one owed
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result word %h with none expected", $time, result);
      end else begin
        due = pending_words.pop_front();
        if (result.running_task !== due.running_task) begin
          failed = 1'b1;
          $display("%0t: running_task expected %0d actual %0d", $time,
                   due.running_task, result.running_task);
        end
        if (result.idle_running !== due.idle_running) begin
          failed = 1'b1;
          $display("%0t: idle_running expected %b actual %b", $time,
                   due.idle_running, result.idle_running);
        end
        if (result.switched !== due.switched) begin
          failed = 1'b1;
          $display("%0t: switched expected %b actual %b", $time,
                   due.switched, result.switched);
        end
        if (result.status !== due.status) begin
          failed = 1'b1;
          $display("%0t: status expected %b actual %b", $time,
                   due.status, result.status);
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    failed    = 1'b0;
    gaps_on   = 1'b1;
    clear_schedule();

    // Directed opening: idle cases, ignored events, rotation, zero and full
    // quanta, blocking down to idle. Expectations typed in where obvious.
    //        func      id     qv     typ  task  idle sw   st
    add_row(FN_TICK,  4'd0,  8'h00, 1, 4'd0,  1, 0, 0);  // tick while idle, queue empty
    add_row(FN_BLOCK, 4'd0,  8'h00, 1, 4'd0,  1, 0, 1);  // block while idle
    add_row(FN_READY, 4'd0,  8'h00, 1, 4'd0,  1, 0, 0);
    add_row(FN_READY, 4'd0,  8'h00, 1, 4'd0,  1, 0, 1);  // already ready
    add_row(FN_TICK,  4'd0,  8'h00, 1, 4'd0,  0, 1, 0);  // idle hands over to task 0
    add_row(FN_READY, 4'd0,  8'h00, 1, 4'd0,  0, 0, 1);  // already running
    add_row(FN_READY, 4'd15, 8'h00, 1, 4'd0,  0, 0, 0);
    add_row(FN_SETQ,  4'd15, 8'h00, 1, 4'd0,  0, 0, 0);  // zero quantum
    add_row(FN_TICK,  4'd0,  8'h00, 1, 4'd0,  0, 0, 0);
    add_row(FN_BLOCK, 4'd0,  8'h00, 1, 4'd15, 0, 1, 0);
    add_row(FN_READY, 4'd0,  8'h00, 1, 4'd15, 0, 0, 0);  // wake a blocked task
    add_row(FN_TICK,  4'd0,  8'h00, 0, 4'd0,  0, 0, 0);  // zero quantum preempted
    add_row(FN_SETQ,  4'd0,  8'hFF, 1, 4'd0,  0, 0, 0);
    add_row(FN_BLOCK, 4'd0,  8'h00, 1, 4'd15, 0, 1, 0);
    add_row(FN_BLOCK, 4'd0,  8'h00, 1, 4'd0,  1, 1, 0);  // queue empty, idle runs
    add_row(FN_BLOCK, 4'd0,  8'h00, 1, 4'd0,  1, 0, 1);
    add_row(FN_READY, 4'd15, 8'h00, 1, 4'd0,  1, 0, 0);
    add_row(FN_TICK,  4'd0,  8'h00, 1, 4'd15, 0, 1, 0);
    add_row(FN_TICK,  4'd0,  8'h00, 1, 4'd15, 0, 0, 0);  // expired, nobody waiting
    add_row(FN_SETQ,  4'd9,  8'hAA, 1, 4'd15, 0, 0, 0);  // free task, default wins later
    add_row(FN_READY, 4'd9,  8'h00, 1, 4'd15, 0, 0, 0);
    add_row(FN_TICK,  4'd0,  8'h00, 0, 4'd0,  0, 0, 0);
    add_row(FN_SETQ,  4'd6,  8'h55, 0, 4'd0,  0, 0, 0);
    add_row(FN_READY, 4'd0,  8'h00, 0, 4'd0,  0, 0, 0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      maybe_pause();
      send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    // Zero default quantum: freshly woken tasks are preempted at once
    drain();
    write_default('0);
    random_phase(170, 1'b1);

    // Full default quantum, plus a long idle stretch into saturation
    drain();
    write_default('1);
    starve_then_wake();
    random_phase(170, 1'b1);

    drain();
    write_default(8'd1);
    random_phase(170, 1'b1);

    // Closing stretch runs back to back with no idling
    drain();
    write_default(pick_quantum());
    random_phase(170, 1'b0);

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("round_robin_quantum_scheduler_tb passed");
    end else begin
      $display("round_robin_quantum_scheduler_tb failed");
    end
    $finish;
  end

endmodule
